>>> sv/fsil_pkg.sv
package fsil_pkg;

  localparam int CAPACITY_DEF = 32;
  localparam int ID_BITS_DEF  = 16;
  localparam int ID_BITS_MAX  = 32;
  localparam int FREQ_W       = 16;
  localparam int PORT_ID_W    = 16;

  localparam logic [1:0] ST_INSERTED = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_ENTRY    = 2'd2;
  localparam logic [1:0] ST_EMPTY    = 2'd3;

  localparam logic ACT_INSERT = 1'b0;
  localparam logic ACT_DUMP   = 1'b1;

endpackage

>>> sv/frequency_sorted_insert_list.sv
// Sorted table of up to CAPACITY (frequency, word handle) entries, kept in
// ascending frequency order; equal frequencies keep arrival order. An insert
// walks down from the top of the table, one stored entry at a time (RAM
// read, then compare and move up by one), past every stored entry with a
// greater frequency, and writes the new entry into the gap, at the bottom
// when every stored entry is greater (empty table included); it then posts
// its single result once the output is free. A full table rejects the
// insert with status 1. A dump streams every entry lowest first, one entry
// at a time (RAM read, then output load), last set on the highest entry;
// an empty table gives one status-3 result. Inserts and dumps share one
// RAM with a read port and a write port, and in_ready is high only between
// requests.
module frequency_sorted_insert_list #(
  parameter int CAPACITY = fsil_pkg::CAPACITY_DEF,
  parameter int ID_BITS  = fsil_pkg::ID_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           in_action,
  input  logic [fsil_pkg::FREQ_W-1:0]    in_frequency,
  input  logic [fsil_pkg::PORT_ID_W-1:0] in_word_id,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [fsil_pkg::FREQ_W-1:0]    out_frequency,
  output logic [fsil_pkg::PORT_ID_W-1:0] out_word_id,
  output logic [1:0]                     out_status,
  output logic                           out_last
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int FW = fsil_pkg::FREQ_W;
  localparam int DW = FW + ID_BITS;

  typedef enum logic [5:0] {
    S_IDLE    = 6'b000001,
    S_INS_RD  = 6'b000010,
    S_INS_CMP = 6'b000100,
    S_EMIT    = 6'b001000,
    S_DMP_RD  = 6'b010000,
    S_DMP_OUT = 6'b100000
  } state_t;

  state_t               state_r, state_nxt;
  logic [CW-1:0]        count_r, count_nxt;
  logic [CW-1:0]        idx_r, idx_nxt;
  logic [FW-1:0]        key_r, key_nxt;
  logic [ID_BITS-1:0]   word_r, word_nxt;
  logic [1:0]           st_r, st_nxt;

  logic                 out_valid_r, out_valid_nxt;
  logic [FW-1:0]        out_freq_r, out_freq_nxt;
  logic [fsil_pkg::PORT_ID_W-1:0] out_word_r, out_word_nxt;
  logic [1:0]           out_status_r, out_status_nxt;
  logic                 out_last_r, out_last_nxt;

  logic                 we, re;
  logic [AW-1:0]        waddr, raddr;
  logic [DW-1:0]        wdata, rdata;
  logic [FW-1:0]        rfreq;
  logic [ID_BITS-1:0]   rword;
  logic [fsil_pkg::ID_BITS_MAX-1:0] in_word_ext, rword_ext;
  logic                 accept, out_free, dump_load;
  logic [CW-1:0]        idx_dec;

  fsil_ram #(.WIDTH(DW), .DEPTH(CAPACITY)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign rfreq       = rdata[DW-1:ID_BITS];
  assign rword       = rdata[ID_BITS-1:0];
  assign in_word_ext = fsil_pkg::ID_BITS_MAX'(in_word_id);
  assign rword_ext   = fsil_pkg::ID_BITS_MAX'(rword);
  assign accept      = in_valid && in_ready;
  assign out_free    = !out_valid_r || out_ready;
  assign idx_dec     = idx_r - 1'b1;
  assign dump_load   = (state_r == S_DMP_OUT) && out_free;

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    idx_nxt        = idx_r;
    key_nxt        = key_r;
    word_nxt       = word_r;
    st_nxt         = st_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_freq_nxt   = out_freq_r;
    out_word_nxt   = out_word_r;
    out_status_nxt = out_status_r;
    out_last_nxt   = out_last_r;
    we             = 1'b0;
    waddr          = idx_r[AW-1:0];
    wdata          = {key_r, word_r};
    re             = 1'b0;
    raddr          = idx_dec[AW-1:0];

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          key_nxt  = in_frequency;
          word_nxt = in_word_ext[ID_BITS-1:0];
          if (in_action == fsil_pkg::ACT_INSERT) begin
            if (count_r == CW'(CAPACITY)) begin
              st_nxt    = fsil_pkg::ST_FULL;
              state_nxt = S_EMIT;
            end else begin
              idx_nxt   = count_r;
              state_nxt = S_INS_RD;
            end
          end else begin
            if (count_r == '0) begin
              st_nxt    = fsil_pkg::ST_EMPTY;
              state_nxt = S_EMIT;
            end else begin
              idx_nxt   = '0;
              state_nxt = S_DMP_RD;
            end
          end
        end
      end
      S_INS_RD: begin
        if (idx_r == '0) begin
          we        = 1'b1;
          count_nxt = count_r + 1'b1;
          st_nxt    = fsil_pkg::ST_INSERTED;
          state_nxt = S_EMIT;
        end else begin
          re        = 1'b1;
          state_nxt = S_INS_CMP;
        end
      end
      S_INS_CMP: begin
        we = 1'b1;
        if (rfreq > key_r) begin
          wdata     = rdata;
          idx_nxt   = idx_dec;
          state_nxt = S_INS_RD;
        end else begin
          count_nxt = count_r + 1'b1;
          st_nxt    = fsil_pkg::ST_INSERTED;
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_freq_nxt   = '0;
          out_word_nxt   = '0;
          out_status_nxt = st_r;
          out_last_nxt   = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      S_DMP_RD: begin
        re        = 1'b1;
        raddr     = idx_r[AW-1:0];
        state_nxt = S_DMP_OUT;
      end
      S_DMP_OUT: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_freq_nxt   = rfreq;
          out_word_nxt   = rword_ext[fsil_pkg::PORT_ID_W-1:0];
          out_status_nxt = fsil_pkg::ST_ENTRY;
          out_last_nxt   = ((idx_r + 1'b1) == count_r);
          if ((idx_r + 1'b1) == count_r) begin
            state_nxt = S_IDLE;
          end else begin
            idx_nxt   = idx_r + 1'b1;
            state_nxt = S_DMP_RD;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    idx_r        <= idx_nxt;
    key_r        <= key_nxt;
    word_r       <= word_nxt;
    st_r         <= st_nxt;
    out_freq_r   <= out_freq_nxt;
    out_word_r   <= out_word_nxt;
    out_status_r <= out_status_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign in_ready      = (state_r == S_IDLE);
  assign out_valid     = out_valid_r;
  assign out_frequency = out_freq_r;
  assign out_word_id   = out_word_r;
  assign out_status    = out_status_r;
  assign out_last      = out_last_r;

  a_full_reject: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_action == fsil_pkg::ACT_INSERT && count_r == CW'(CAPACITY))
    |=> (state_r == S_EMIT && st_r == fsil_pkg::ST_FULL))
    else $error("full insert not rejected");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && count_r != $past(count_r))
    |-> (count_r == $past(count_r) + 1'b1 && $past(state_r) != S_IDLE))
    else $error("entry count moved by other than one insert");

  a_dump_range: assert property (@(posedge clk) disable iff (!rst_n)
    dump_load |-> (idx_r < count_r))
    else $error("dump read beyond stored entries");

  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_INS_CMP || state_r == S_INS_RD) |-> (count_r < CW'(CAPACITY)))
    else $error("insert running on a full table");

endmodule

>>> sv/fsil_ram.sv
module fsil_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
